### src/cia64_pkg.sv
`timescale 1ns / 1ps
// Shared types for the checked 64-bit constant ALU: request and response
// structs, operation codes and the pipeline stage records. No dependencies.
package cia64_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned DivSteps = DataW;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_SHL = 4'd8,
        OP_SHR = 4'd9,
        OP_NEG = 4'd10
    } t_op;

    localparam logic [3:0] OpLast = OP_NEG;
    localparam logic [DataW-1:0] MinMag = {1'b1, {(DataW-1){1'b0}}};
    localparam logic [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};

    typedef struct packed {
        logic [3:0]       req_type;
        logic             left_negative;
        logic [DataW-1:0] left_magnitude;
        logic             right_negative;
        logic [DataW-1:0] right_magnitude;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic             result_negative;
        logic [DataW-1:0] result_magnitude;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic             ok;
        logic             sa;
        logic             sb;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] ma;
        logic [DataW-1:0] mb;
    } t_dec;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic             ok;
        logic             sa;
        logic             qneg;
        logic [DataW-1:0] ma;
        logic [DataW-1:0] mb;
        logic [DataW-1:0] res;
        logic [DataW-1:0] pp0;
        logic [DataW-1:0] pp1;
        logic [DataW-1:0] pp2;
        logic [DataW-1:0] pp3;
    } t_mul;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic             ok;
        logic             sa;
        logic             qneg;
        logic [DataW-1:0] mb;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dq;
        logic             res_neg;
        logic [DataW-1:0] res_mag;
    } t_div;

endpackage

### src/cia64_div_step.sv
`timescale 1ns / 1ps
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on cia64_pkg for the stage record.
module cia64_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  cia64_pkg::t_div i_d,
    output cia64_pkg::t_div o_d
);
    import cia64_pkg::*;

    t_div                 r_d;
    t_div                 n_d;
    logic [DataW-1:0]     w_sh;
    logic [DataW:0]       w_diff;

    always_comb begin
        n_d    = i_d;
        w_sh   = {i_d.rem[DataW-2:0], i_d.dq[DataW-1]};
        w_diff = {1'b0, w_sh} - {1'b0, i_d.mb};
        if (!w_diff[DataW]) begin
            n_d.rem = w_diff[DataW-1:0];
            n_d.dq  = {i_d.dq[DataW-2:0], 1'b1};
        end else begin
            n_d.rem = w_sh;
            n_d.dq  = {i_d.dq[DataW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_adv) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

### src/checked_int64_constant_alu_core.sv
`timescale 1ns / 1ps
// Checked signed 64-bit ALU on sign-magnitude operands, fully pipelined.
// Depends on cia64_pkg and cia64_div_step.
//
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_stall   i_req (t_req)
//  response  out        o_valid / i_stall   o_rsp (t_rsp)
//
// One request enters per cycle while o_stall is low; each response passes through
// stages s0, s1, s2, the 64-stage divider (one quotient bit per stage) and the output register.
// Reset empties the pipeline. The whole pipeline holds while the output
// register is full and stalled; nothing is dropped or repeated.
module checked_int64_constant_alu_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cia64_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output cia64_pkg::t_rsp o_rsp
);
    import cia64_pkg::*;

    logic w_adv;
    t_dec r_s0, n_s0;
    t_mul r_s1, n_s1;
    t_div r_s2, n_s2;
    t_div w_dv [0:DivSteps];
    logic r_out_valid;
    t_rsp r_out, n_out;

    logic [DataW-1:0]   w_r;
    logic [DataW-1:0]   w_shl;
    logic [5:0]         w_amt;
    logic [2*DataW-1:0] w_prod;
    logic [DataW-1:0]   w_lim;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    always_comb begin
        n_s0       = '0;
        n_s0.valid = i_valid;
        n_s0.op    = t_op'(i_req.req_type);
        n_s0.sa    = i_req.left_negative && (i_req.left_magnitude != '0);
        n_s0.sb    = i_req.right_negative && (i_req.right_magnitude != '0);
        n_s0.ma    = i_req.left_magnitude;
        n_s0.mb    = i_req.right_magnitude;
        n_s0.a     = i_req.left_negative ? ('0 - i_req.left_magnitude)
                                         : i_req.left_magnitude;
        n_s0.b     = i_req.right_negative ? ('0 - i_req.right_magnitude)
                                          : i_req.right_magnitude;
        n_s0.ok    = (i_req.req_type <= OpLast);
        if (i_req.left_negative ? (i_req.left_magnitude > MinMag)
                                : (i_req.left_magnitude > MaxPos)) begin
            n_s0.ok = 1'b0;
        end
        if (i_req.req_type != OP_NEG) begin
            if (i_req.right_negative ? (i_req.right_magnitude > MinMag)
                                     : (i_req.right_magnitude > MaxPos)) begin
                n_s0.ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_s1       = '0;
        n_s1.valid = r_s0.valid;
        n_s1.op    = r_s0.op;
        n_s1.ok    = r_s0.ok;
        n_s1.sa    = r_s0.sa;
        n_s1.qneg  = r_s0.sa ^ r_s0.sb;
        n_s1.ma    = r_s0.ma;
        n_s1.mb    = r_s0.mb;
        n_s1.pp0   = DataW'(r_s0.ma[31:0] * r_s0.mb[31:0]);
        n_s1.pp1   = DataW'(r_s0.ma[31:0] * r_s0.mb[63:32]);
        n_s1.pp2   = DataW'(r_s0.ma[63:32] * r_s0.mb[31:0]);
        n_s1.pp3   = DataW'(r_s0.ma[63:32] * r_s0.mb[63:32]);
        w_amt      = r_s0.b[5:0];
        w_shl      = r_s0.a << w_amt;
        w_r        = '0;
        case (r_s0.op)
            OP_ADD: begin
                w_r = r_s0.a + r_s0.b;
                if (r_s0.a[63] == r_s0.b[63] && w_r[63] != r_s0.a[63]) n_s1.ok = 1'b0;
            end
            OP_SUB: begin
                w_r = r_s0.a - r_s0.b;
                if (r_s0.a[63] != r_s0.b[63] && w_r[63] != r_s0.a[63]) n_s1.ok = 1'b0;
            end
            OP_DIV, OP_MOD: begin
                if (r_s0.b == '0 || (r_s0.a == MinMag && r_s0.b == '1)) n_s1.ok = 1'b0;
            end
            OP_AND: w_r = r_s0.a & r_s0.b;
            OP_OR:  w_r = r_s0.a | r_s0.b;
            OP_XOR: w_r = r_s0.a ^ r_s0.b;
            OP_SHL, OP_SHR: begin
                if (r_s0.a[63] || r_s0.b[63] || r_s0.b[63:6] != '0) begin
                    n_s1.ok = 1'b0;
                end else if (r_s0.op == OP_SHL) begin
                    w_r = w_shl;
                    if (w_shl[63] || (w_shl >> w_amt) != r_s0.a) n_s1.ok = 1'b0;
                end else begin
                    w_r = r_s0.a >> w_amt;
                end
            end
            OP_NEG: begin
                w_r = '0 - r_s0.a;
                if (r_s0.a == MinMag) n_s1.ok = 1'b0;
            end
            default: w_r = '0;
        endcase
        n_s1.res = w_r;
    end

    always_comb begin
        n_s2       = '0;
        n_s2.valid = r_s1.valid;
        n_s2.op    = r_s1.op;
        n_s2.ok    = r_s1.ok;
        n_s2.sa    = r_s1.sa;
        n_s2.qneg  = r_s1.qneg;
        n_s2.mb    = r_s1.mb;
        n_s2.rem   = '0;
        n_s2.dq    = r_s1.ma;
        w_prod     = {{DataW{1'b0}}, r_s1.pp0}
                   + ({{DataW{1'b0}}, r_s1.pp1} << 32)
                   + ({{DataW{1'b0}}, r_s1.pp2} << 32)
                   + {r_s1.pp3, {DataW{1'b0}}};
        w_lim      = r_s1.qneg ? MinMag : MaxPos;
        if (r_s1.op == OP_MUL) begin
            if (w_prod > {{DataW{1'b0}}, w_lim}) n_s2.ok = 1'b0;
            n_s2.res_neg = r_s1.qneg && (w_prod[DataW-1:0] != '0);
            n_s2.res_mag = w_prod[DataW-1:0];
        end else begin
            n_s2.res_neg = r_s1.res[63];
            n_s2.res_mag = r_s1.res[63] ? ('0 - r_s1.res) : r_s1.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (w_adv) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign w_dv[0] = r_s2;

    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        cia64_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_d     (w_dv[g]),
            .o_d     (w_dv[g+1])
        );
    end

    always_comb begin
        n_out = '0;
        if (w_dv[DivSteps].ok) begin
            n_out.ok = 1'b1;
            case (w_dv[DivSteps].op)
                OP_DIV: begin
                    n_out.result_magnitude = w_dv[DivSteps].dq;
                    n_out.result_negative  = w_dv[DivSteps].qneg
                                             && (w_dv[DivSteps].dq != '0);
                end
                OP_MOD: begin
                    n_out.result_magnitude = w_dv[DivSteps].rem;
                    n_out.result_negative  = w_dv[DivSteps].sa
                                             && (w_dv[DivSteps].rem != '0);
                end
                default: begin
                    n_out.result_magnitude = w_dv[DivSteps].res_mag;
                    n_out.result_negative  = w_dv[DivSteps].res_neg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_dv[DivSteps].valid;
            r_out       <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.ok) |-> (!o_rsp.result_negative && o_rsp.result_magnitude == '0))
        else $error("failed response carries a nonzero result");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.ok && !o_rsp.result_negative) |-> !o_rsp.result_magnitude[63])
        else $error("positive result out of signed range");

    a_neg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.ok && o_rsp.result_negative)
            |-> (o_rsp.result_magnitude != '0
                 && (!o_rsp.result_magnitude[63] || o_rsp.result_magnitude == MinMag)))
        else $error("negative result out of signed range");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("response valid right after reset");

endmodule

### test/checked_int64_constant_alu_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for checked_int64_constant_alu_core: a directed table
// followed by random requests with and without random idling, checked against a predictor.
// Depends on cia64_pkg and the core.
module checked_int64_constant_alu_core_test;
    import cia64_pkg::*;

    localparam int unsigned RandomCount = 1500;
    localparam int unsigned Latency = 68;
    localparam int unsigned WatchdogLimit = 5000;
    localparam int unsigned PendingDepth = 256;
    localparam int unsigned DirectedCount = 26;
    localparam logic [63:0] AllOnes = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    typedef struct {
        t_req req;
        logic has_rsp;
        t_rsp rsp;
    } t_row;

    t_rsp folded_results[0:PendingDepth-1];
    int unsigned fold_wr = 0;
    int unsigned fold_rd = 0;
    t_row vectors[0:DirectedCount-1];
    int unsigned row_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    checked_int64_constant_alu_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_rsp fold(input t_req req);
        t_rsp rsp;
        logic [63:0] a, b, r, ma, mb, lim;
        logic sa, sb, ok;
        logic [127:0] prod;
        rsp = '0;
        ok = 1'b1;
        r = '0;
        if (req.req_type > OpLast) return rsp;
        if (req.left_negative ? req.left_magnitude > MinMag : req.left_magnitude > MaxPos)
            return rsp;
        a = req.left_negative ? -req.left_magnitude : req.left_magnitude;
        if (t_op'(req.req_type) == OP_NEG) begin
            if (a == MinMag) return rsp;
            r = -a;
        end else begin
            if (req.right_negative ? req.right_magnitude > MinMag
                                   : req.right_magnitude > MaxPos) return rsp;
            b = req.right_negative ? -req.right_magnitude : req.right_magnitude;
            sa = a[63];
            sb = b[63];
            ma = sa ? -a : a;
            mb = sb ? -b : b;
            case (t_op'(req.req_type))
                OP_ADD: begin
                    r = a + b;
                    if (sa == sb && r[63] != sa) ok = 1'b0;
                end
                OP_SUB: begin
                    r = a - b;
                    if (sa != sb && r[63] != sa) ok = 1'b0;
                end
                OP_MUL: begin
                    lim = (sa ^ sb) ? MinMag : MaxPos;
                    prod = ma * mb;
                    if (prod > {64'd0, lim}) ok = 1'b0;
                    r = (sa ^ sb) ? -prod[63:0] : prod[63:0];
                end
                OP_DIV, OP_MOD: begin
                    if (b == 0 || (a == MinMag && b == AllOnes)) ok = 1'b0;
                    else if (t_op'(req.req_type) == OP_DIV) begin
                        r = ma / mb;
                        if (sa ^ sb) r = -r;
                    end else begin
                        r = ma % mb;
                        if (sa) r = -r;
                    end
                end
                OP_AND: r = a & b;
                OP_OR:  r = a | b;
                OP_XOR: r = a ^ b;
                default: begin
                    if (sa || sb || b >= 64) ok = 1'b0;
                    else if (t_op'(req.req_type) == OP_SHL) begin
                        if (a > (MaxPos >> b)) ok = 1'b0;
                        else r = a << b;
                    end else begin
                        r = a >> b;
                    end
                end
            endcase
            if (!ok) return rsp;
        end
        rsp.ok = 1'b1;
        rsp.result_negative = r[63];
        rsp.result_magnitude = r[63] ? -r : r;
        return rsp;
    endfunction

    function automatic logic [63:0] pick_mag();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return MinMag;
            2: return MaxPos;
            3: return MinMag + 64'($urandom_range(1, 3));
            4: return 64'($urandom_range(0, 70));
            5: return {$urandom, $urandom} >> $urandom_range(0, 63);
            6: return 64'($urandom) >> $urandom_range(0, 31);
            default: return {1'b0, 31'($urandom), $urandom};
        endcase
    endfunction

    function automatic t_req pick_req();
        t_req req;
        req.req_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                    : 4'($urandom_range(0, 10));
        req.left_negative = 1'($urandom);
        req.left_magnitude = pick_mag();
        req.right_negative = 1'($urandom);
        req.right_magnitude = pick_mag();
        return req;
    endfunction

    function automatic t_row row(input t_op op, input logic ln, input logic [63:0] lm,
                                 input logic rn, input logic [63:0] rm,
                                 input logic has_rsp, input t_rsp rsp);
        t_row r;
        r.req = '{req_type: op, left_negative: ln, left_magnitude: lm,
                  right_negative: rn, right_magnitude: rm};
        r.has_rsp = has_rsp;
        r.rsp = rsp;
        return r;
    endfunction

    task automatic add_row(input t_row r);
        vectors[row_count] = r;
        row_count++;
    endtask

    task automatic send(input t_req req, input logic has_rsp, input t_rsp rsp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= req;
        folded_results[fold_wr % PendingDepth] = has_rsp ? rsp : fold(req);
        fold_wr++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (fold_wr == fold_rd) begin
                $error("response with no request outstanding");
                error_count++;
            end else begin
                want = folded_results[fold_rd % PendingDepth];
                fold_rd++;
                if (o_rsp.ok !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, o_rsp.ok);
                    error_count++;
                end
                if (o_rsp.result_negative !== want.result_negative) begin
                    $error("result_negative: expected %0b, got %0b",
                           want.result_negative, o_rsp.result_negative);
                    error_count++;
                end
                if (o_rsp.result_magnitude !== want.result_magnitude) begin
                    $error("result_magnitude: expected %0h, got %0h",
                           want.result_magnitude, o_rsp.result_magnitude);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_rsp fail_rsp;
        t_rsp pos_max;
        t_rsp neg_min;
        t_rsp zero_rsp;
        int unsigned phase;
        int unsigned k;
        fail_rsp = '0;
        pos_max = '{ok: 1'b1, result_negative: 1'b0, result_magnitude: MaxPos};
        neg_min = '{ok: 1'b1, result_negative: 1'b1, result_magnitude: MinMag};
        zero_rsp = '{ok: 1'b1, result_negative: 1'b0, result_magnitude: 64'd0};
        add_row(row(OP_ADD, 0, 0, 1, 0, 1, zero_rsp));
        add_row(row(OP_ADD, 0, MaxPos, 0, 1, 1, fail_rsp));
        add_row(row(OP_ADD, 1, MinMag, 1, 1, 1, fail_rsp));
        add_row(row(OP_ADD, 1, MinMag + 1, 0, 0, 1, fail_rsp));
        add_row(row(OP_ADD, 0, MinMag, 0, 0, 1, fail_rsp));
        add_row(row(OP_SUB, 0, 0, 1, MinMag, 1, fail_rsp));
        add_row(row(OP_SUB, 1, MinMag, 0, 0, 1, neg_min));
        add_row(row(OP_MUL, 0, 64'd1 << 32, 0, 64'd1 << 31, 1, fail_rsp));
        add_row(row(OP_MUL, 1, 64'd1 << 32, 0, 64'd1 << 31, 1, neg_min));
        add_row(row(OP_MUL, 1, MinMag, 1, 1, 1, fail_rsp));
        add_row(row(OP_DIV, 0, 5, 1, 0, 1, fail_rsp));
        add_row(row(OP_DIV, 1, MinMag, 1, 1, 1, fail_rsp));
        add_row(row(OP_DIV, 1, 7, 0, 2, 0, fail_rsp));
        add_row(row(OP_MOD, 1, 7, 0, 2, 0, fail_rsp));
        add_row(row(OP_MOD, 1, MinMag, 1, 1, 0, fail_rsp));
        add_row(row(OP_AND, 1, MinMag, 0, MaxPos, 1, zero_rsp));
        add_row(row(OP_OR, 1, MinMag, 0, MaxPos, 0, fail_rsp));
        add_row(row(OP_XOR, 1, 1, 0, MaxPos, 0, fail_rsp));
        add_row(row(OP_SHL, 0, 1, 0, 62, 0, fail_rsp));
        add_row(row(OP_SHL, 0, 1, 0, 63, 1, fail_rsp));
        add_row(row(OP_SHL, 1, 1, 0, 1, 1, fail_rsp));
        add_row(row(OP_SHR, 0, MaxPos, 0, 64, 1, fail_rsp));
        add_row(row(OP_SHR, 0, MaxPos, 1, 1, 1, fail_rsp));
        add_row(row(OP_NEG, 1, MinMag, 0, 0, 1, fail_rsp));
        add_row(row(OP_NEG, 1, MaxPos, 1, AllOnes, 1, pos_max));
        add_row(row(t_op'(4'd15), 0, 1, 0, 1, 1, fail_rsp));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (k = 0; k < row_count; k++) begin
            send(vectors[k].req, vectors[k].has_rsp, vectors[k].rsp);
        end
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 30 : 0;
            repeat (RandomCount / 3) send(pick_req(), 1'b0, fail_rsp);
        end
        i_valid <= 1'b0;
        recv_idle_pct = 0;
        while (fold_rd != fold_wr) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### files.f
src/cia64_pkg.sv
src/cia64_div_step.sv
src/checked_int64_constant_alu_core.sv
test/checked_int64_constant_alu_core_test.sv
